// ----- src/btmx_pkg.sv -----
package btmx_pkg;

    localparam int KEY_BITS   = 31;
    localparam int NODE_SLOTS = 4096;
    localparam int COUNT_BITS = 16;

    localparam int NODE_W = $clog2(NODE_SLOTS);
    localparam int TOP_W  = NODE_W + 1;
    localparam int LVL_W  = $clog2(KEY_BITS + 1);
    localparam int KIDX_W = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_INS = 2'd0,
        CMD_ERA = 2'd1,
        CMD_QRY = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_INS_CHK,
        ACT_INS_START,
        ACT_INS_WALK,
        ACT_POP,
        ACT_LINK,
        ACT_LEAF,
        ACT_ERA_CHK,
        ACT_ERA_RD,
        ACT_ERA_UPD,
        ACT_QRY,
        ACT_OUT
    } t_act;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_INS_CHK,
        S_INS_WALK,
        S_INS_POP,
        S_INS_LINK,
        S_INS_LEAF,
        S_ERA_CHK,
        S_ERA_RD,
        S_ERA_UPD,
        S_QRY,
        S_DONE
    } t_state;

    typedef struct packed {
        t_act    act;
        logic    fin;
        t_status code;
    } t_ctrl;

    typedef struct packed {
        t_cmd cmd;
        logic rem_zero;
        logic rem_one;
        logic cnt_full;
        logic cnt_zero;
        logic nxt_null;
        logic oth_null;
        logic need_over;
        logic up_last;
        logic root_empty;
        logic out_free;
    } t_stat;

endpackage

// ----- src/binary_trie_max_xor_core.sv -----
// channel   direction  handshake                   payload
// request   in         i_in_valid / o_in_ready     i_command, i_key
// result    out        o_out_valid / i_out_ready   o_best_xor, o_status
//
// one transaction is worked on at a time; one node memory read per trie level
// query: walks down from the top level, taking the opposite child where one exists
// insert: checks the levels, walks them, then takes and links a new node per missing level
// erase: checks the key path top-down, then reads and updates each level bottom-up
// reset: synchronous, active low; free stack is live at once, no clearing pass
// a result waiting in the output register stalls only the finish of the next one
module binary_trie_max_xor_core
    import btmx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_command,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KEY_BITS-1:0] o_best_xor,
    output logic [1:0]          o_status
);

    // sequencer commands and datapath flags
    t_ctrl ctrl;
    t_stat stat;

    // state machine: walks levels, decides refusals and the final status
    btmx_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (stat),
        .o_ctrl    (ctrl)
    );

    // node memories, free stack, root registers and result register
    btmx_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .i_command  (i_command),
        .i_key      (i_key),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_best_xor (o_best_xor),
        .o_status   (o_status)
    );

endmodule

// ----- src/btmx_ram.sv -----
module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/btmx_ctrl.sv -----
module btmx_ctrl
    import btmx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISP;
            end
            S_DISP: begin
                case (i_stat.cmd)
                    CMD_INS: n_state = S_INS_CHK;
                    CMD_ERA: n_state = S_ERA_CHK;
                    CMD_QRY: n_state = S_QRY;
                    default: n_state = S_DONE;
                endcase
            end
            S_INS_CHK: begin
                if (i_stat.cnt_full) n_state = S_DONE;
                else if (i_stat.rem_zero) n_state = S_INS_WALK;
                else if (i_stat.nxt_null) n_state = i_stat.need_over ? S_DONE : S_INS_WALK;
            end
            S_INS_WALK: begin
                if (i_stat.rem_zero) n_state = S_DONE;
                else if (i_stat.nxt_null) n_state = S_INS_POP;
            end
            S_INS_POP:  n_state = S_INS_LINK;
            S_INS_LINK: n_state = i_stat.rem_one ? S_INS_LEAF : S_INS_POP;
            S_INS_LEAF: n_state = S_DONE;
            S_ERA_CHK: begin
                if (i_stat.cnt_zero) n_state = S_DONE;
                else if (i_stat.rem_zero) n_state = S_ERA_RD;
                else if (i_stat.nxt_null) n_state = S_DONE;
            end
            S_ERA_RD:  n_state = S_ERA_UPD;
            S_ERA_UPD: n_state = i_stat.up_last ? S_DONE : S_ERA_RD;
            S_QRY: begin
                if (i_stat.root_empty || i_stat.rem_zero) n_state = S_DONE;
                else if (i_stat.oth_null && i_stat.nxt_null) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl      = '{act: ACT_NONE, fin: 1'b0, code: ST_OK};
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctrl.act = ACT_LOAD;
            end
            S_INS_CHK: begin
                if (i_stat.cnt_full) begin
                    o_ctrl.fin  = 1'b1;
                    o_ctrl.code = ST_FULL;
                end else if (i_stat.rem_zero) begin
                    o_ctrl.act = ACT_INS_START;
                end else if (i_stat.nxt_null) begin
                    if (i_stat.need_over) begin
                        o_ctrl.fin  = 1'b1;
                        o_ctrl.code = ST_FULL;
                    end else begin
                        o_ctrl.act = ACT_INS_START;
                    end
                end else begin
                    o_ctrl.act = ACT_INS_CHK;
                end
            end
            S_INS_WALK: o_ctrl.act = ACT_INS_WALK;
            S_INS_POP:  o_ctrl.act = ACT_POP;
            S_INS_LINK: o_ctrl.act = ACT_LINK;
            S_INS_LEAF: o_ctrl.act = ACT_LEAF;
            S_ERA_CHK: begin
                if (i_stat.cnt_zero) begin
                    o_ctrl.fin  = 1'b1;
                    o_ctrl.code = ST_ABSENT;
                end else if (i_stat.rem_zero) begin
                    o_ctrl.act = ACT_NONE;
                end else if (i_stat.nxt_null) begin
                    o_ctrl.fin  = 1'b1;
                    o_ctrl.code = ST_ABSENT;
                end else begin
                    o_ctrl.act = ACT_ERA_CHK;
                end
            end
            S_ERA_RD:  o_ctrl.act = ACT_ERA_RD;
            S_ERA_UPD: o_ctrl.act = ACT_ERA_UPD;
            S_QRY: begin
                if (i_stat.root_empty) begin
                    o_ctrl.fin  = 1'b1;
                    o_ctrl.code = ST_EMPTY;
                end else begin
                    o_ctrl.act = ACT_QRY;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) o_ctrl.act = ACT_OUT;
            end
            default: o_ctrl.act = ACT_NONE;
        endcase
    end

endmodule

// ----- src/btmx_dp.sv -----
module btmx_dp
    import btmx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl               i_ctrl,
    output t_stat               o_stat,
    input  logic [1:0]          i_command,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KEY_BITS-1:0] o_best_xor,
    output logic [1:0]          o_status
);

    localparam logic [LVL_W-1:0]  REM_FULL = LVL_W'(KEY_BITS);
    localparam logic [LVL_W-1:0]  REM_LAST = LVL_W'(KEY_BITS - 1);
    localparam logic [KIDX_W-1:0] IDX_LAST = KIDX_W'(KEY_BITS - 1);
    localparam logic [NODE_W-1:0] ROOT     = '0;

    // walk state
    t_cmd                  r_cmd,   n_cmd;
    logic [KEY_BITS-1:0]   r_key,   n_key;
    logic [LVL_W-1:0]      r_rem,   n_rem;
    logic [NODE_W-1:0]     r_cur,   n_cur;
    logic [NODE_W-1:0]     r_par,   n_par;
    logic [KEY_BITS-1:0]   r_best,  n_best;
    t_status               r_status, n_status;
    logic                  r_virgin, n_virgin;
    logic                  r_fresh,  n_fresh;
    logic                  r_freeing, n_freeing;
    logic [NODE_W-1:0]     r_path [KEY_BITS];

    // root node and free stack bookkeeping
    logic [NODE_W-1:0]     r_rootz, n_rootz;
    logic [NODE_W-1:0]     r_rooto, n_rooto;
    logic [COUNT_BITS-1:0] r_rootcnt, n_rootcnt;
    logic [TOP_W-1:0]      r_top, n_top;
    logic [TOP_W-1:0]      r_low, n_low;

    // result register
    logic                  r_ovalid, n_ovalid;
    logic [KEY_BITS-1:0]   r_obest,  n_obest;
    t_status               r_ostatus, n_ostatus;

    // memory ports
    logic                  cz_we, co_we, cnt_we, stk_we;
    logic [NODE_W-1:0]     cz_waddr, co_waddr;
    logic [NODE_W-1:0]     cz_wdata, co_wdata;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [NODE_W-1:0]     cz_rd, co_rd, stk_rd;
    logic [COUNT_BITS-1:0] cnt_rd;
    logic [NODE_W-1:0]     stk_wdata;

    logic                  path_we;
    logic [LVL_W-1:0]      depth_now;
    logic [KIDX_W-1:0]     path_widx;
    logic [KIDX_W-1:0]     path_ridx;

    logic [LVL_W-1:0]      rem_m1;
    logic [KIDX_W-1:0]     bidx;
    logic                  kbit;
    logic                  ubit;
    logic [NODE_W-1:0]     cur_z, cur_o, nxt, oth, new_node;
    logic [COUNT_BITS-1:0] cur_cnt, dec_cnt;
    logic [TOP_W-1:0]      pop_idx;
    logic                  freeable;

    assign rem_m1    = r_rem - LVL_W'(1);
    assign bidx      = rem_m1[KIDX_W-1:0];
    assign kbit      = r_key[bidx];
    assign ubit      = r_key[r_rem[KIDX_W-1:0]];
    assign cur_z     = (r_cur == ROOT) ? r_rootz : cz_rd;
    assign cur_o     = (r_cur == ROOT) ? r_rooto : co_rd;
    assign cur_cnt   = (r_cur == ROOT) ? r_rootcnt : cnt_rd;
    assign nxt       = kbit ? cur_o : cur_z;
    assign oth       = kbit ? cur_z : cur_o;
    assign dec_cnt   = (cnt_rd != '0) ? cnt_rd - COUNT_BITS'(1) : cnt_rd;
    assign freeable  = (dec_cnt == '0) && (cz_rd == '0) && (co_rd == '0);
    assign pop_idx   = r_top - TOP_W'(1);
    assign new_node  = r_virgin ? NODE_W'(r_top + TOP_W'(1)) : stk_rd;
    assign depth_now = REM_FULL - r_rem;
    assign path_widx = depth_now[KIDX_W-1:0];
    assign path_ridx = IDX_LAST - r_rem[KIDX_W-1:0];

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.rem_zero   = (r_rem == '0);
        o_stat.rem_one    = (r_rem == LVL_W'(1));
        o_stat.cnt_full   = (cur_cnt == COUNT_MAX);
        o_stat.cnt_zero   = (r_cur != ROOT) && (cnt_rd == '0);
        o_stat.nxt_null   = (nxt == ROOT);
        o_stat.oth_null   = (oth == ROOT);
        o_stat.need_over  = (TOP_W'(r_rem) > r_top);
        o_stat.up_last    = (r_rem == REM_LAST);
        o_stat.root_empty = (r_rootcnt == '0);
        o_stat.out_free   = !r_ovalid || i_out_ready;
    end

    always_comb begin
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_rem     = r_rem;
        n_cur     = r_cur;
        n_par     = r_par;
        n_best    = r_best;
        n_status  = r_status;
        n_virgin  = r_virgin;
        n_fresh   = r_fresh;
        n_freeing = r_freeing;
        n_rootz   = r_rootz;
        n_rooto   = r_rooto;
        n_rootcnt = r_rootcnt;
        n_top     = r_top;
        n_low     = r_low;
        n_ovalid  = r_ovalid && !i_out_ready;
        n_obest   = r_obest;
        n_ostatus = r_ostatus;

        cz_we     = 1'b0;
        co_we     = 1'b0;
        cnt_we    = 1'b0;
        stk_we    = 1'b0;
        cz_waddr  = r_cur;
        co_waddr  = r_cur;
        cz_wdata  = '0;
        co_wdata  = '0;
        cnt_wdata = '0;
        stk_wdata = r_cur;
        path_we   = 1'b0;

        case (i_ctrl.act)
            ACT_LOAD: begin
                n_cmd     = t_cmd'(i_command);
                n_key     = i_key;
                n_rem     = REM_FULL;
                n_cur     = ROOT;
                n_best    = '0;
                n_status  = ST_OK;
                n_fresh   = 1'b0;
                n_freeing = 1'b1;
            end
            ACT_INS_CHK: begin
                if (r_rem != '0 && nxt != ROOT) begin
                    n_cur = nxt;
                    n_rem = rem_m1;
                end
            end
            ACT_INS_START: begin
                n_cur     = ROOT;
                n_rem     = REM_FULL;
                n_rootcnt = r_rootcnt + COUNT_BITS'(1);
            end
            ACT_INS_WALK: begin
                if (r_cur != ROOT) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rd + COUNT_BITS'(1);
                end
                if (r_rem != '0 && nxt != ROOT) begin
                    n_cur = nxt;
                    n_rem = rem_m1;
                end
            end
            ACT_POP: begin
                n_top    = pop_idx;
                n_virgin = (pop_idx < r_low);
                if (pop_idx < r_low) n_low = pop_idx;
            end
            ACT_LINK: begin
                if (r_fresh) begin
                    // parent was taken in this transaction: write its whole node
                    cz_we     = 1'b1;
                    co_we     = 1'b1;
                    cnt_we    = 1'b1;
                    cz_wdata  = kbit ? ROOT : new_node;
                    co_wdata  = kbit ? new_node : ROOT;
                    cnt_wdata = COUNT_BITS'(1);
                end else if (r_cur == ROOT) begin
                    if (kbit) n_rooto = new_node;
                    else n_rootz = new_node;
                end else begin
                    cz_we    = !kbit;
                    co_we    = kbit;
                    cz_wdata = new_node;
                    co_wdata = new_node;
                end
                n_cur   = new_node;
                n_rem   = rem_m1;
                n_fresh = 1'b1;
            end
            ACT_LEAF: begin
                cz_we     = 1'b1;
                co_we     = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = COUNT_BITS'(1);
            end
            ACT_ERA_CHK: begin
                if (r_rem != '0) begin
                    path_we = 1'b1;
                    if (nxt != ROOT) begin
                        n_cur = nxt;
                        n_rem = rem_m1;
                    end
                end
            end
            ACT_ERA_RD: begin
                n_par = r_path[path_ridx];
            end
            ACT_ERA_UPD: begin
                cnt_we    = 1'b1;
                cnt_wdata = dec_cnt;
                if (r_freeing && freeable) begin
                    if (r_par == ROOT) begin
                        if (ubit) n_rooto = ROOT;
                        else n_rootz = ROOT;
                    end else begin
                        cz_we    = !ubit;
                        co_we    = ubit;
                        cz_waddr = r_par;
                        co_waddr = r_par;
                    end
                    if (r_top < TOP_W'(NODE_SLOTS)) begin
                        stk_we = 1'b1;
                        n_top  = r_top + TOP_W'(1);
                    end
                end else begin
                    n_freeing = 1'b0;
                end
                n_cur = r_par;
                n_rem = r_rem + LVL_W'(1);
                if (r_rem == REM_LAST && r_rootcnt != '0) begin
                    n_rootcnt = r_rootcnt - COUNT_BITS'(1);
                end
            end
            ACT_QRY: begin
                if (r_rem != '0) begin
                    if (oth != ROOT) begin
                        n_best = r_best | (KEY_BITS'(1) << bidx);
                        n_cur  = oth;
                        n_rem  = rem_m1;
                    end else if (nxt != ROOT) begin
                        n_cur = nxt;
                        n_rem = rem_m1;
                    end
                end
            end
            ACT_OUT: begin
                n_ovalid  = 1'b1;
                n_obest   = r_best;
                n_ostatus = r_status;
            end
            default: begin
                n_cmd = r_cmd;
            end
        endcase

        if (i_ctrl.fin) n_status = i_ctrl.code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rootz   <= '0;
            r_rooto   <= '0;
            r_rootcnt <= '0;
            r_top     <= TOP_W'(NODE_SLOTS - 1);
            r_low     <= TOP_W'(NODE_SLOTS - 1);
            r_ovalid  <= 1'b0;
            r_fresh   <= 1'b0;
            r_freeing <= 1'b0;
            r_virgin  <= 1'b0;
        end else begin
            r_rootz   <= n_rootz;
            r_rooto   <= n_rooto;
            r_rootcnt <= n_rootcnt;
            r_top     <= n_top;
            r_low     <= n_low;
            r_ovalid  <= n_ovalid;
            r_fresh   <= n_fresh;
            r_freeing <= n_freeing;
            r_virgin  <= n_virgin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_key     <= n_key;
        r_rem     <= n_rem;
        r_cur     <= n_cur;
        r_par     <= n_par;
        r_best    <= n_best;
        r_status  <= n_status;
        r_obest   <= n_obest;
        r_ostatus <= n_ostatus;
        if (path_we) r_path[path_widx] <= r_cur;
    end

    btmx_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_child_zero (
        .i_clk  (i_clk),
        .i_we   (cz_we),
        .i_waddr(cz_waddr),
        .i_wdata(cz_wdata),
        .i_raddr(n_cur),
        .o_rdata(cz_rd)
    );

    btmx_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_child_one (
        .i_clk  (i_clk),
        .i_we   (co_we),
        .i_waddr(co_waddr),
        .i_wdata(co_wdata),
        .i_raddr(n_cur),
        .o_rdata(co_rd)
    );

    btmx_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_SLOTS)) u_pass_count (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(r_cur),
        .i_wdata(cnt_wdata),
        .i_raddr(n_cur),
        .o_rdata(cnt_rd)
    );

    btmx_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_free_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(r_top[NODE_W-1:0]),
        .i_wdata(stk_wdata),
        .i_raddr(pop_idx[NODE_W-1:0]),
        .o_rdata(stk_rd)
    );

    assign o_out_valid = r_ovalid;
    assign o_best_xor  = r_obest;
    assign o_status    = r_ostatus;

`ifndef SYNTH
    a_low_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_top)
        else $error("free stack low mark above top");

    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(NODE_SLOTS - 1))
        else $error("free stack holds more nodes than exist");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.act == ACT_POP |-> r_top != '0)
        else $error("node taken from an empty free stack");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_ostatus != ST_OK |-> r_obest == '0)
        else $error("nonzero xor with a failing status");
`endif

endmodule
